@@ rtl/mrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared codes and field widths of the mesh request tracker.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int BASE_W     = 21;
    localparam int ELAPSED_W  = 21;
    localparam int DEADLINE_W = 22;
    localparam int EST_W      = 20;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] DIR_REQUEST  = 2'd0;
    localparam logic [1:0] DIR_CONFIRM  = 2'd1;
    localparam logic [1:0] DIR_RESPONSE = 2'd2;

    localparam logic [2:0] ST_CREATED   = 3'd0;
    localparam logic [2:0] ST_SENT      = 3'd1;
    localparam logic [2:0] ST_CONFIRMED = 3'd2;
    localparam logic [2:0] ST_PROCESSED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    localparam logic [2:0] ERR_NONE            = 3'd0;
    localparam logic [2:0] ERR_ALREADY_SENT    = 3'd1;
    localparam logic [2:0] ERR_NOT_RESPONSE    = 3'd2;
    localparam logic [2:0] ERR_NOT_IN_PROGRESS = 3'd3;
    localparam logic [2:0] ERR_WRONG_PERIPH    = 3'd4;
    localparam logic [2:0] ERR_WRONG_COMMAND   = 3'd5;

    localparam logic [BASE_W-1:0] BASE_INFINITE = '1;

endpackage

@@ rtl/mesh_request_tracker_top.sv @@
// Mesh request tracker. Accepts one request per cycle unless the output
// stalls and returns exactly one result per request. Its path runs through
// the hop/slot estimate multiply, the input register, the deadline add and
// checks, then the result register that also updates the tracking state.
// Write cfg_wr_data (base timeout, ms, -1 = infinite) only while idle.
// ----------------------------------------------------------------------------
// mesh_request_tracker_top
// Tracks one mesh request through sent, confirmed, processed and timed out.
// ----------------------------------------------------------------------------
module mesh_request_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [20:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // peripheral, command_code, hops, slot_length, hops_response
    input  logic [39:0] s_tdata,
    // cmd, direction
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, error, in_progress, zero pad
    output logic [7:0]  m_tdata
);

    logic [mrt_pkg::BASE_W-1:0] base_reg;

    logic                        in_valid_reg;
    logic [1:0]                  cmd_reg;
    logic [1:0]                  dir_reg;
    logic [7:0]                  per_reg;
    logic [7:0]                  code_reg;
    logic [mrt_pkg::EST_W-1:0]   est_reg;

    logic [2:0]                      status_reg, status_next;
    logic [7:0]                      sent_per_reg, sent_per_next;
    logic [7:0]                      sent_cmd_reg, sent_cmd_next;
    logic [mrt_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next, elapsed_inc;
    logic [mrt_pkg::DEADLINE_W-1:0]  deadline_reg, deadline_next, arm_deadline;
    logic                            inf_reg, inf_next;

    logic                            m_valid_reg;
    logic [7:0]                      m_data_reg;

    logic                            advance;
    logic                            in_fire;
    logic [2:0]                      err;
    logic                            do_arm;
    logic                            active;

    // estimate datapath
    logic [8:0]                      hops_p1;
    logic [8:0]                      hresp_p1;
    logic [16:0]                     hop_slot;
    logic [7:0]                      rslot;
    logic [16:0]                     resp_part;
    logic [mrt_pkg::EST_W-1:0]       est;

    logic [mrt_pkg::EST_W-1:0]       arm_extra;
    logic signed [22:0]              arm_sum;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign hops_p1  = {1'b0, s_tdata[23:16]} + 9'd1;
    assign hresp_p1 = {1'b0, s_tdata[39:32]} + 9'd1;
    assign hop_slot = hops_p1 * s_tdata[31:24];

    always_comb begin
        if (s_tdata[31:24] == 8'd20) begin
            rslot = 8'd200;
        end else if (s_tdata[31:24] > 8'd6) begin
            rslot = 8'd100;
        end else begin
            rslot = 8'd50;
        end
    end

    assign resp_part = hresp_p1 * rslot;
    assign est = {hop_slot, 3'b000} + {2'b00, hop_slot, 1'b0}
               + {3'b000, resp_part} + mrt_pkg::EST_W'(40);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= mrt_pkg::BASE_INFINITE;
        end else if (cfg_wr_en) begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg  <= s_tuser[1:0];
            dir_reg  <= s_tuser[3:2];
            per_reg  <= s_tdata[7:0];
            code_reg <= s_tdata[15:8];
            est_reg  <= est;
        end
    end

    assign arm_extra = (cmd_reg == mrt_pkg::CMD_SEND) ? '0 : est_reg;
    assign arm_sum   = {{2{base_reg[mrt_pkg::BASE_W-1]}}, base_reg}
                     + signed'({3'b000, arm_extra});
    assign arm_deadline = arm_sum[22] ? '0 : arm_sum[mrt_pkg::DEADLINE_W-1:0];

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign active = (status_reg == mrt_pkg::ST_SENT)
                 || (status_reg == mrt_pkg::ST_CONFIRMED);

    always_comb begin
        status_next   = status_reg;
        sent_per_next = sent_per_reg;
        sent_cmd_next = sent_cmd_reg;
        elapsed_next  = elapsed_reg;
        deadline_next = deadline_reg;
        inf_next      = inf_reg;
        err           = mrt_pkg::ERR_NONE;
        do_arm        = 1'b0;
        case (cmd_reg)
            mrt_pkg::CMD_SEND: begin
                if (status_reg != mrt_pkg::ST_CREATED) begin
                    err = mrt_pkg::ERR_ALREADY_SENT;
                end else begin
                    status_next   = mrt_pkg::ST_SENT;
                    sent_per_next = per_reg;
                    sent_cmd_next = code_reg;
                    do_arm        = 1'b1;
                end
            end
            mrt_pkg::CMD_RECV: begin
                if (dir_reg != mrt_pkg::DIR_CONFIRM && dir_reg != mrt_pkg::DIR_RESPONSE) begin
                    err = mrt_pkg::ERR_NOT_RESPONSE;
                end else if (!active) begin
                    err = mrt_pkg::ERR_NOT_IN_PROGRESS;
                end else if (per_reg != sent_per_reg) begin
                    err = mrt_pkg::ERR_WRONG_PERIPH;
                end else if ({1'b0, code_reg[6:0]} != sent_cmd_reg) begin
                    err = mrt_pkg::ERR_WRONG_COMMAND;
                end else if (dir_reg == mrt_pkg::DIR_CONFIRM) begin
                    status_next = mrt_pkg::ST_CONFIRMED;
                    do_arm      = 1'b1;
                end else begin
                    status_next = mrt_pkg::ST_PROCESSED;
                end
            end
            mrt_pkg::CMD_TICK: begin
                elapsed_next = elapsed_inc;
                if (active && !inf_reg && ({1'b0, elapsed_inc} > deadline_reg)) begin
                    status_next = mrt_pkg::ST_TIMEOUT;
                end
            end
            default: begin
            end
        endcase
        if (do_arm) begin
            if (base_reg == mrt_pkg::BASE_INFINITE) begin
                inf_next = 1'b1;
            end else begin
                inf_next      = 1'b0;
                elapsed_next  = '0;
                deadline_next = arm_deadline;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg   <= mrt_pkg::ST_CREATED;
            elapsed_reg  <= '0;
            deadline_reg <= '0;
            inf_reg      <= 1'b1;
        end else if (advance) begin
            status_reg   <= status_next;
            elapsed_reg  <= elapsed_next;
            deadline_reg <= deadline_next;
            inf_reg      <= inf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sent_per_reg <= sent_per_next;
            sent_cmd_reg <= sent_cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {1'b0,
                           (status_next == mrt_pkg::ST_SENT)
                               || (status_next == mrt_pkg::ST_CONFIRMED),
                           err, status_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/mrt_checker.sv @@
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks of the mesh request tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mrt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6] == ((m_tdata[2:0] == mrt_pkg::ST_SENT)
                                 || (m_tdata[2:0] == mrt_pkg::ST_CONFIRMED)))
        else $error("in_progress disagrees with status");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= mrt_pkg::ST_TIMEOUT
                  && m_tdata[5:3] <= mrt_pkg::ERR_WRONG_COMMAND && !m_tdata[7])
        else $error("result code out of range");

    a_err_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:3] == mrt_pkg::ERR_ALREADY_SENT)
            |-> m_tdata[2:0] != mrt_pkg::ST_CREATED)
        else $error("already-sent error while created");

endmodule

bind mesh_request_tracker_top mrt_checker u_mrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
